>>> rtl/vti_pkg.sv
// ---------------------------------------------------------------------------
// vti_pkg
// shared types and constants of the vlan tag insert / strip unit
// ---------------------------------------------------------------------------
package vti_pkg;

    localparam int unsigned CMD_W      = 2;
    localparam int unsigned PORT_W     = 8;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned POS_W      = 14;
    localparam int unsigned VID_W      = 12;
    localparam int unsigned PCP_W      = 3;
    localparam int unsigned MAX_W      = 14;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 14;
    localparam int unsigned PHASE_W    = 3;

    localparam int unsigned ADDR_BYTES = 12;
    localparam int unsigned TAG_BYTES  = 4;
    localparam logic [31:0] TPID_WORD  = 32'h8100_0000;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic [VID_W-1:0] VID_RST = VID_W'(1);
    localparam logic [PCP_W-1:0] PCP_RST = '0;
    localparam logic [MAX_W-1:0] MAX_RST = MAX_W'(2048);

    typedef enum logic [CMD_W-1:0] {
        CMD_PASS   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_STRIP  = 2'd2,
        CMD_DROP   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VLAN_ID   = 2'd0,
        CFG_VLAN_PRIO = 2'd1,
        CFG_MAX_BYTES = 2'd2
    } t_cfg_idx;

endpackage

>>> rtl/vlan_tag_insert_strip_unit.sv
// ---------------------------------------------------------------------------
// vlan_tag_insert_strip_unit
// per-copy 802.1q tag insert / strip on a byte stream
// ---------------------------------------------------------------------------
// One frame byte is taken per cycle, unless an insert or the output stalls,
// and edited between an input register and an output register. Pass and strip
// copies run at one byte per cycle while the output is free, strip copies
// giving no output for the four dropped tag bytes. An insert copy holds its
// twelfth byte in the input register while the byte and the four tag bytes go
// out, so the input stalls while the tag of a tagged frame goes out. The edit
// mode and port are taken from the first byte of each copy; a too_long flag
// marks the final output of a tagged copy longer than the configured maximum.
module vlan_tag_insert_strip_unit
    import vti_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // port, data_byte
    input  logic [CMD_W-1:0]      s_axis_tuser,   // cmd
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,   // out_port, out_byte
    output logic [1:0]            m_axis_tuser,   // byte_valid, too_long
    output logic                  m_axis_tlast
);

    logic [VID_W-1:0]   r_vid;
    logic [PCP_W-1:0]   r_pcp;
    logic [MAX_W-1:0]   r_max;

    logic [POS_W-1:0]   r_pos;
    t_cmd               r_mode;
    logic [PORT_W-1:0]  r_port;

    logic               r_in_valid;
    t_cmd               r_in_cmd;
    logic [PORT_W-1:0]  r_in_port;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_in_last;
    logic [PHASE_W-1:0] r_phase;

    logic               r_out_valid;
    logic [PORT_W-1:0]  r_out_port;
    logic [BYTE_W-1:0]  r_out_byte;
    logic               r_out_bv;
    logic               r_out_last;
    logic               r_out_tl;

    t_cmd               w_mode;
    logic [PORT_W-1:0]  w_port;
    logic [PHASE_W-1:0] w_count;
    logic [BYTE_W-1:0]  w_byte;
    logic               w_bv;
    logic               w_last;
    logic               w_tl;
    logic [POS_W:0]     w_len;
    logic               w_over;
    logic [15:0]        w_tci;
    logic               w_out_free;
    logic               w_out_load;
    logic               w_done;
    logic [PHASE_W-1:0] n_phase;
    logic [POS_W-1:0]   n_pos;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vid <= VID_RST;
            r_pcp <= PCP_RST;
            r_max <= MAX_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_VLAN_ID:   r_vid <= i_cfg_wdata[VID_W-1:0];
                CFG_VLAN_PRIO: r_pcp <= i_cfg_wdata[PCP_W-1:0];
                CFG_MAX_BYTES: r_max <= i_cfg_wdata[MAX_W-1:0];
                default: ;
            endcase
        end
    end

    // edit decision for the held byte
    always_comb begin
        w_mode  = (r_pos == '0) ? r_in_cmd : r_mode;
        w_port  = (r_pos == '0) ? r_in_port : r_port;
        w_tci   = {r_pcp, 1'b0, r_vid};
        w_len   = {1'b0, r_pos} + (POS_W+1)'(TAG_BYTES + 1);
        w_over  = w_len > {1'b0, r_max};
        w_count = PHASE_W'(1);
        w_byte  = r_in_byte;
        w_bv    = 1'b1;
        w_last  = r_in_last;
        w_tl    = 1'b0;
        case (w_mode)
            CMD_PASS: ;
            CMD_INSERT: begin
                if (r_pos == POS_W'(ADDR_BYTES - 1)) begin
                    w_count = PHASE_W'(TAG_BYTES + 1);
                    case (r_phase)
                        3'd0:    w_byte = r_in_byte;
                        3'd1:    w_byte = TPID_WORD[31:24];
                        3'd2:    w_byte = TPID_WORD[23:16];
                        3'd3:    w_byte = w_tci[15:8];
                        default: w_byte = w_tci[7:0];
                    endcase
                    w_last = r_in_last && (r_phase == PHASE_W'(TAG_BYTES));
                    w_tl   = w_last && w_over;
                end else if (r_pos > POS_W'(ADDR_BYTES - 1)) begin
                    w_tl = r_in_last && w_over;
                end
            end
            CMD_STRIP: begin
                if (r_pos >= POS_W'(ADDR_BYTES) &&
                    r_pos <  POS_W'(ADDR_BYTES + TAG_BYTES)) begin
                    w_count = r_in_last ? PHASE_W'(1) : '0;
                    w_byte  = '0;
                    w_bv    = 1'b0;
                end
            end
            default: w_count = '0;
        endcase
    end

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_out_load    = r_in_valid && (w_count != '0) && w_out_free;
    assign w_done        = r_in_valid &&
                           ((w_count == '0) ||
                            (w_out_load && (r_phase == w_count - PHASE_W'(1))));
    assign s_axis_tready = !r_in_valid || w_done;

    always_comb begin
        n_phase = r_phase;
        if (w_done) begin
            n_phase = '0;
        end else if (w_out_load) begin
            n_phase = r_phase + PHASE_W'(1);
        end
        n_pos = r_pos;
        if (w_done) begin
            if (r_in_last) begin
                n_pos = '0;
            end else if (r_pos < POS_MAX) begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= '0;
            r_pos       <= '0;
            r_mode      <= CMD_PASS;
            r_port      <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_out_free) begin
                r_out_valid <= w_out_load;
            end
            if (w_done && r_pos == '0) begin
                r_mode <= w_mode;
                r_port <= w_port;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_cmd  <= t_cmd'(s_axis_tuser);
            r_in_port <= s_axis_tdata[PORT_W-1:0];
            r_in_byte <= s_axis_tdata[PORT_W +: BYTE_W];
            r_in_last <= s_axis_tlast;
        end
        if (w_out_load) begin
            r_out_port <= w_port;
            r_out_byte <= w_byte;
            r_out_bv   <= w_bv;
            r_out_last <= w_last;
            r_out_tl   <= w_tl;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_byte, r_out_port};
    assign m_axis_tuser  = {r_out_tl, r_out_bv};
    assign m_axis_tlast  = r_out_last;

    a_tl_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("too_long flag away from the final output");

    a_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata[15:8] == '0)
        else $error("bare end marker malformed");

    a_phase_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != '0 |-> r_in_valid && w_mode == CMD_INSERT)
        else $error("tag phase outside an insert copy");

    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid)
        else $error("input stalled with nothing held");

endmodule

>>> sim/vlan_tag_insert_strip_unit_tb.sv
// ---------------------------------------------------------------------------
// vlan_tag_insert_strip_unit_tb
// self-checking regression of the vlan tag insert / strip unit
// ---------------------------------------------------------------------------
// Frame copies are streamed in one byte per request. A table of directed
// copies at the reset settings covers the field extremes, every edit mode,
// short and boundary frames and strips ending inside the tag. Random phases
// follow, each under new register settings, with frame lengths clustered
// around the tag bytes and the size limit. Every accepted byte runs through
// an in-bench model of the edit; output requests are compared field by field
// in order. Both sides idle at random, the sink holds off once for a long
// stretch, and the source drains the block between phases.
module vlan_tag_insert_strip_unit_tb;
    import vti_pkg::*;

    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int RX_HOLD      = 300;
    localparam int DRAIN_PAD    = 8;
    localparam int PHASE_BYTES  = 12;
    localparam int USE_MODEL    = -1;
    localparam int N_ROWS       = 20;

    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [BYTE_W-1:0] data;
        logic              vld;
        logic              last;
        logic              too_long;
    } egress_byte_t;

    typedef struct {
        t_cmd              cmd;
        logic [PORT_W-1:0] port;
        int                len;
        logic [BYTE_W-1:0] first;
        bit                scramble;
        int                typed_n;
        egress_byte_t      typed;
    } frame_row_t;

    localparam egress_byte_t NO_RES = '0;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata  = '0;   // port, data_byte
    logic [CMD_W-1:0]      s_axis_tuser  = '0;   // cmd
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;         // out_port, out_byte
    logic [1:0]            m_axis_tuser;         // byte_valid, too_long
    logic                  m_axis_tlast;

    vlan_tag_insert_strip_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // model copy of the registers and the per-copy state
    logic [VID_W-1:0]  cfg_vid = VID_RST;
    logic [PCP_W-1:0]  cfg_pcp = PCP_RST;
    logic [MAX_W-1:0]  cfg_max = MAX_RST;
    logic [POS_W-1:0]  frm_pos = '0;
    t_cmd              frm_mode = CMD_PASS;
    logic [PORT_W-1:0] frm_port = '0;

    egress_byte_t edit_out[$];
    egress_byte_t egress_expected[$];

    int           drv_typed_n = USE_MODEL;
    egress_byte_t drv_typed_res = '0;

    bit tx_burst;
    bit hold_rx;
    int n_errors;
    int n_checked;
    int n_flagged;
    int n_frames;
    int n_items;

    frame_row_t directed [N_ROWS];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_CYCLES * 20);
        $display("vlan_tag_insert_strip_unit regression: fail");
        $finish;
    end

    function automatic void add_result(logic [BYTE_W-1:0] b, logic v, logic l, logic tl);
        egress_byte_t r;
        r.port     = frm_port;
        r.data     = b;
        r.vld      = v;
        r.last     = l;
        r.too_long = tl;
        edit_out.push_back(r);
    endfunction

    function automatic void predict_edit(t_cmd c, logic [PORT_W-1:0] p,
                                         logic [BYTE_W-1:0] b, logic l);
        logic [31:0]      tag;
        logic             tl;
        logic [POS_W-1:0] pos;
        edit_out.delete();
        if (frm_pos == '0) begin
            frm_mode = c;
            frm_port = p;
        end
        pos = frm_pos;
        tl  = (32'(pos) + 32'd1 + TAG_BYTES) > 32'(cfg_max);
        case (frm_mode)
            CMD_PASS: begin
                add_result(b, 1'b1, l, 1'b0);
            end
            CMD_INSERT: begin
                if (pos < ADDR_BYTES - 1) begin
                    add_result(b, 1'b1, l, 1'b0);
                end else if (pos == ADDR_BYTES - 1) begin
                    tag = TPID_WORD | 32'(cfg_vid) | (32'(cfg_pcp) << 13);
                    add_result(b, 1'b1, 1'b0, 1'b0);
                    add_result(tag[31:24], 1'b1, 1'b0, 1'b0);
                    add_result(tag[23:16], 1'b1, 1'b0, 1'b0);
                    add_result(tag[15:8], 1'b1, 1'b0, 1'b0);
                    add_result(tag[7:0], 1'b1, l, l & tl);
                end else begin
                    add_result(b, 1'b1, l, l & tl);
                end
            end
            CMD_STRIP: begin
                if (pos >= ADDR_BYTES && pos < ADDR_BYTES + TAG_BYTES) begin
                    if (l) add_result('0, 1'b0, 1'b1, 1'b0);
                end else begin
                    add_result(b, 1'b1, l, 1'b0);
                end
            end
            default: ;
        endcase
        if (l) frm_pos = '0;
        else if (frm_pos != POS_MAX) frm_pos = frm_pos + 1'b1;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        egress_byte_t got;
        egress_byte_t want;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_edit(t_cmd'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[15:8],
                         s_axis_tlast);
            if (drv_typed_n == USE_MODEL) begin
                foreach (edit_out[k]) egress_expected.push_back(edit_out[k]);
            end else if (drv_typed_n == 1) begin
                egress_expected.push_back(drv_typed_res);
            end
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.port     = m_axis_tdata[7:0];
            got.data     = m_axis_tdata[15:8];
            got.vld      = m_axis_tuser[0];
            got.too_long = m_axis_tuser[1];
            got.last     = m_axis_tlast;
            n_checked++;
            if (got.too_long) n_flagged++;
            if (egress_expected.size() == 0) begin
                if (n_errors < 10)
                    $display("unexpected output: port %h byte %h vld %b last %b too_long %b",
                             got.port, got.data, got.vld, got.last, got.too_long);
                n_errors++;
            end else begin
                want = egress_expected.pop_front();
                if (got.port !== want.port || got.data !== want.data || got.vld !== want.vld
                        || got.last !== want.last || got.too_long !== want.too_long) begin
                    if (n_errors < 10)
                        $display("mismatch: exp port %h byte %h vld %b last %b too_long %b, %s",
                                 want.port, want.data, want.vld, want.last, want.too_long,
                                 $sformatf("got port %h byte %h vld %b last %b too_long %b",
                                           got.port, got.data, got.vld, got.last,
                                           got.too_long));
                    n_errors++;
                end
            end
        end
    end

    initial begin : egress_sink
        int stall;
        int run;
        bit quiet;
        run   = 0;
        quiet = 1'b0;
        forever begin
            if (run == 0) begin
                run   = $urandom_range(1, 60);
                quiet = ($urandom_range(0, 3) == 0);
            end
            run--;
            stall = quiet ? 0 : $urandom_range(0, 14);
            if (hold_rx) begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD) @(posedge i_clk);
                hold_rx = 1'b0;
            end else if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && i_rst_n) && !hold_rx);
        end
    end

    task automatic send_byte(t_cmd c, logic [PORT_W-1:0] p, logic [BYTE_W-1:0] b, logic l,
                             int typed_n, egress_byte_t typed_res);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, p};
        s_axis_tuser  <= c;
        s_axis_tlast  <= l;
        drv_typed_n   <= typed_n;
        drv_typed_res <= typed_res;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_frame(t_cmd c, logic [PORT_W-1:0] p, int len, logic [BYTE_W-1:0] first,
                              bit scramble, int typed_n, egress_byte_t typed_res);
        logic [BYTE_W-1:0] b;
        logic [PORT_W-1:0] pp;
        t_cmd              cc;
        for (int i = 0; i < len; i++) begin
            b  = (i == 0) ? first : BYTE_W'($urandom);
            cc = c;
            pp = p;
            // cmd and port beyond the first byte must be ignored
            if (scramble && i > 0) begin
                cc = t_cmd'($urandom_range(0, 3));
                pp = PORT_W'($urandom);
            end
            send_byte(cc, pp, b, i == len - 1, typed_n, typed_res);
        end
        n_frames++;
        if (c != CMD_DROP) n_items += len;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (egress_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic write_config(logic [VID_W-1:0] vid, logic [PCP_W-1:0] pcp,
                                logic [MAX_W-1:0] mx);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= CFG_VLAN_ID;
        i_cfg_wdata <= CFG_DATA_W'(vid);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_VLAN_PRIO;
        i_cfg_wdata <= CFG_DATA_W'(pcp);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_MAX_BYTES;
        i_cfg_wdata <= CFG_DATA_W'(mx);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_vid = vid;
        cfg_pcp = pcp;
        cfg_max = mx;
    endtask

    initial begin : stimulus
        int   phase_items;
        int   sel;
        int   len;
        int   k;
        t_cmd c;
        directed = '{
            '{CMD_PASS,   8'hFF,     1, 8'hFF, 1'b0, 1, '{8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0}},
            '{CMD_PASS,   8'h00,     1, 8'h00, 1'b0, 1, '{8'h00, 8'h00, 1'b1, 1'b1, 1'b0}},
            '{CMD_DROP,   8'hAA,     1, 8'h55, 1'b0, 0, NO_RES},
            '{CMD_INSERT, 8'h3C,     1, 8'h81, 1'b0, 1, '{8'h3C, 8'h81, 1'b1, 1'b1, 1'b0}},
            '{CMD_STRIP,  8'hC3,     1, 8'h7E, 1'b0, 1, '{8'hC3, 8'h7E, 1'b1, 1'b1, 1'b0}},
            '{CMD_PASS,   8'h11,     8, 8'h01, 1'b1, USE_MODEL, NO_RES},
            '{CMD_INSERT, 8'h22,     5, 8'h02, 1'b0, USE_MODEL, NO_RES},
            '{CMD_INSERT, 8'h33,    11, 8'h03, 1'b0, USE_MODEL, NO_RES},
            '{CMD_INSERT, 8'h44,    12, 8'h04, 1'b0, USE_MODEL, NO_RES},
            '{CMD_INSERT, 8'h55,    13, 8'h05, 1'b0, USE_MODEL, NO_RES},
            '{CMD_INSERT, 8'h66,    24, 8'h06, 1'b1, USE_MODEL, NO_RES},
            '{CMD_STRIP,  8'h77,    12, 8'h07, 1'b0, USE_MODEL, NO_RES},
            '{CMD_STRIP,  8'h88,    13, 8'h08, 1'b0, USE_MODEL, NO_RES},
            '{CMD_STRIP,  8'h99,    14, 8'h09, 1'b0, USE_MODEL, NO_RES},
            '{CMD_STRIP,  8'hA0,    15, 8'h0A, 1'b0, USE_MODEL, NO_RES},
            '{CMD_STRIP,  8'hB0,    16, 8'h0B, 1'b0, USE_MODEL, NO_RES},
            '{CMD_STRIP,  8'hC0,    17, 8'h0C, 1'b0, USE_MODEL, NO_RES},
            '{CMD_STRIP,  8'hD0,    24, 8'h0D, 1'b1, USE_MODEL, NO_RES},
            '{CMD_DROP,   8'hE0,     8, 8'h0E, 1'b1, USE_MODEL, NO_RES},
            '{CMD_PASS,   8'h01,     3, 8'h12, 1'b0, USE_MODEL, NO_RES}
        };
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[r]) begin
            tx_burst = (directed[r].len > 20);
            send_frame(directed[r].cmd, directed[r].port, directed[r].len, directed[r].first,
                       directed[r].scramble, directed[r].typed_n, directed[r].typed);
        end

        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            case (ph)
                0:       write_config(VID_W'(4095), PCP_W'(7), MAX_W'(16383));
                1:       write_config(VID_W'(0), PCP_W'(0), MAX_W'(64));
                2:       write_config(VID_W'($urandom), PCP_W'($urandom),
                                      MAX_W'($urandom_range(0, 63)));
                default: write_config(VID_W'($urandom), PCP_W'($urandom),
                                      MAX_W'($urandom_range(64, 16383)));
            endcase
            // sink stalls long while the source keeps the block full
            if (ph == 0) hold_rx = 1'b1;
            phase_items = 0;
            k = 0;
            while (phase_items < PHASE_BYTES) begin
                sel = $urandom_range(0, 99);
                if (sel < 30)      c = CMD_INSERT;
                else if (sel < 60) c = CMD_STRIP;
                else if (sel < 90) c = CMD_PASS;
                else               c = CMD_DROP;
                sel = $urandom_range(0, 99);
                if (sel < 40)      len = $urandom_range(1, 16);
                else if (sel < 70) len = $urandom_range(10, 18);
                else if (sel < 90) len = int'(cfg_max) - 6 + $urandom_range(0, 8);
                else               len = $urandom_range(17, 60);
                if (len < 1)  len = 1;
                if (len > 80) len = 80;
                tx_burst = (ph == 0 && k < 3) || ($urandom_range(0, 4) == 0);
                send_frame(c, PORT_W'($urandom), len, BYTE_W'($urandom),
                           $urandom_range(0, 1), USE_MODEL, NO_RES);
                if (c != CMD_DROP) phase_items += len;
                k++;
            end
        end
        wait_idle();

        $display("covered %0d frame copies with %0d edited bytes under 5 register settings,",
                 n_frames, n_items);
        $display("checked %0d output bytes, %0d of them flagged too long", n_checked, n_flagged);
        if (n_errors == 0 && egress_expected.size() == 0) begin
            $display("vlan_tag_insert_strip_unit regression: pass");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("vlan_tag_insert_strip_unit regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/vti_pkg.sv
rtl/vlan_tag_insert_strip_unit.sv
sim/vlan_tag_insert_strip_unit_tb.sv
